// ===== design/tmld_pkg.sv =====
package tmld_pkg;

  localparam int unsigned DeltaW = 28;
  localparam int unsigned TimeW  = 32;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // position inside a move group
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2,
    POS_FOURTH = 2'd3
  } group_pos_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_word_t;

  typedef struct packed {
    logic [1:0]       move_dir;
    logic [TimeW-1:0] move_time;
    logic             list_done;
    logic             bad_list;
  } move_word_t;

  // handshake between decode stage and result register
  typedef struct packed {
    logic res_valid;
    logic advance;
  } stage_ctl_t;

endpackage

// ===== design/tmld_in_reg.sv =====
module tmld_in_reg
  import tmld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_word_t byte_word,
  input  logic       advance,
  output logic       stage_valid,
  output byte_word_t stage_word
);

  logic load;

  assign byte_stall = stage_valid && !advance;
  assign load       = byte_valid && !byte_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_word <= byte_word;
    end
  end

endmodule

// ===== design/tmld_decode.sv =====
module tmld_decode
  import tmld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       stage_valid,
  input  byte_word_t stage_word,
  input  logic       out_free,
  output stage_ctl_t ctl,
  output move_word_t res_word
);

  group_pos_t        pos;
  group_pos_t        pos_next;
  logic [DeltaW-1:0] partial;
  logic [DeltaW-1:0] partial_next;
  logic [1:0]        held_dir;
  logic [1:0]        dir_next;
  logic [TimeW-1:0]  time_base;
  logic [TimeW-1:0]  time_base_next;
  logic              complete;
  logic              last;
  logic [7:0]        b;
  logic [TimeW:0]    sum;
  logic [TimeW:0]    sum_inc;
  logic [TimeW-1:0]  t_sat;
  logic [TimeW-1:0]  t_inc_sat;

  assign b    = stage_word.data_byte;
  assign last = stage_word.last_byte;

  always_comb begin
    pos_next     = pos;
    partial_next = partial;
    dir_next     = held_dir;
    complete     = 1'b0;
    case (pos)
      POS_FIRST: begin
        dir_next     = b[1:0];
        partial_next = {{(DeltaW-5){1'b0}}, b[7:3]};
        if (b[2]) begin
          pos_next = POS_SECOND;
        end else begin
          complete = 1'b1;
        end
      end
      POS_SECOND: begin
        partial_next = partial | {{(DeltaW-12){1'b0}}, b[7:1], 5'b0};
        if (b[0]) begin
          pos_next = POS_THIRD;
        end else begin
          complete = 1'b1;
        end
      end
      POS_THIRD: begin
        partial_next = partial | {{(DeltaW-20){1'b0}}, b, 12'b0};
        pos_next     = POS_FOURTH;
      end
      POS_FOURTH: begin
        partial_next = {b, partial[19:0]};
        complete     = 1'b1;
      end
      default: begin
        pos_next = POS_FIRST;
      end
    endcase
  end

  // move time and next base computed side by side, both saturating
  assign sum       = {1'b0, time_base} + {{(TimeW-DeltaW+1){1'b0}}, partial_next};
  assign sum_inc   = {1'b0, time_base} + {{(TimeW-DeltaW+1){1'b0}}, partial_next}
                     + {{TimeW{1'b0}}, 1'b1};
  assign t_sat     = sum[TimeW] ? TimeMax : sum[TimeW-1:0];
  assign t_inc_sat = sum_inc[TimeW] ? TimeMax : sum_inc[TimeW-1:0];

  always_comb begin
    ctl.res_valid = stage_valid && (complete || last);
    ctl.advance   = stage_valid && (!(complete || last) || out_free);
    if (complete) begin
      res_word.move_dir  = dir_next;
      res_word.move_time = t_sat;
      res_word.list_done = last;
      res_word.bad_list  = 1'b0;
    end else begin
      res_word.move_dir  = 2'd0;
      res_word.move_time = '0;
      res_word.list_done = 1'b1;
      res_word.bad_list  = 1'b1;
    end
    if (last) begin
      time_base_next = '0;
    end else if (complete) begin
      time_base_next = t_inc_sat;
    end else begin
      time_base_next = time_base;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= POS_FIRST;
      time_base <= '0;
    end else if (ctl.advance) begin
      pos       <= (complete || last) ? POS_FIRST : pos_next;
      time_base <= time_base_next;
    end
  end

  // first byte of a group overwrites these, so no reset needed
  always_ff @(posedge clk) begin
    if (ctl.advance) begin
      partial  <= partial_next;
      held_dir <= dir_next;
    end
  end

endmodule

// ===== design/tmld_out_reg.sv =====
module tmld_out_reg
  import tmld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  move_word_t res_word,
  output logic       out_free,
  output logic       move_valid,
  input  logic       move_stall,
  output move_word_t move_word
);

  logic load;

  assign out_free = !move_valid || !move_stall;
  assign load     = ctl.res_valid && ctl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_valid <= 1'b0;
    end else if (load) begin
      move_valid <= 1'b1;
    end else if (!move_stall) begin
      move_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      move_word <= res_word;
    end
  end

endmodule

// ===== design/timed_move_list_decoder.sv =====
// Channel | Direction | Handshake               | Word
// --------+-----------+-------------------------+----------------------------------
// byte    | in        | byte_valid / byte_stall | data_byte, last_byte
// move    | out       | move_valid / move_stall | move_dir, move_time, list_done,
//         |           |                         | bad_list
//
// One byte word per cycle sustained while the move channel is not stalled; a
// word passes the input register, decode and result register to the move channel.
// The 28-bit delta add and saturation sit between the input and result registers.
// Reset (rst, synchronous) empties both registers, starts at the first byte of a
// group and zeroes the time base.
// A stalled move channel holds the result; the input register then fills and
// byte_stall rises. Bytes that finish no move keep flowing past a held result.
module timed_move_list_decoder
  import tmld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_word_t byte_word,
  output logic       move_valid,
  input  logic       move_stall,
  output move_word_t move_word
);

  logic       stage_valid;
  byte_word_t stage_word;
  stage_ctl_t ctl;
  move_word_t res_word;
  logic       out_free;

  // input register
  tmld_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_word   (byte_word),
    .advance     (ctl.advance),
    .stage_valid (stage_valid),
    .stage_word  (stage_word)
  );

  // group assembly, time base, saturating time add
  tmld_decode u_decode (
    .clk         (clk),
    .rst         (rst),
    .stage_valid (stage_valid),
    .stage_word  (stage_word),
    .out_free    (out_free),
    .ctl         (ctl),
    .res_word    (res_word)
  );

  // result register toward the consumer
  tmld_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .res_word   (res_word),
    .out_free   (out_free),
    .move_valid (move_valid),
    .move_stall (move_stall),
    .move_word  (move_word)
  );

  // an error word always closes the list and carries no move
  a_bad_word : assert property (@(posedge clk) disable iff (rst)
    move_valid && move_word.bad_list |->
      move_word.list_done && move_word.move_time == '0 && move_word.move_dir == 2'd0)
    else $error("bad_list word with move content");

  // input only backs up while the stage holds a word it cannot retire
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> stage_valid && ctl.res_valid && move_valid && move_stall)
    else $error("byte_stall without blocked result");

  // a result never overwrites an untaken word
  a_no_overwrite : assert property (@(posedge clk) disable iff (rst)
    ctl.res_valid && ctl.advance |-> !move_valid || !move_stall)
    else $error("result register overwritten");

  // a held stage word always makes progress once the result side frees up
  a_progress : assert property (@(posedge clk) disable iff (rst)
    stage_valid && !move_valid |-> ctl.advance)
    else $error("stage stuck with free result register");

endmodule
